// ----- src/fib_pkg.sv -----
// Shared constants, types and helpers for the fetch instruction buffer.
package fib_pkg;

  // Ring depth must be a multiple of the lane count, and the lane count a power of two.
  localparam int BUFFER_DEPTH = 16;
  localparam int LANES        = 4;
  localparam int LANE_FIELDS  = 4;
  localparam int NUM_LANES    = (LANES < LANE_FIELDS) ? LANES : LANE_FIELDS;

  localparam int PTR_W     = $clog2(BUFFER_DEPTH);
  localparam int OCC_W     = $clog2(BUFFER_DEPTH + 1);
  localparam int SUM_W     = OCC_W + 1;
  localparam int LANE_W    = (NUM_LANES > 1) ? $clog2(NUM_LANES) : 1;
  localparam int ROW_DEPTH = BUFFER_DEPTH / NUM_LANES;
  localparam int ROW_W     = (ROW_DEPTH > 1) ? $clog2(ROW_DEPTH) : 1;

  localparam int ENTRY_W     = 64;
  localparam int PC_W        = 32;
  localparam int CNT_W       = 3;
  localparam int CFG_W       = 3;
  localparam int APB_DATA_W  = 32;
  localparam int APB_ADDR_W  = 3;

  typedef logic [ENTRY_W-1:0] entry_t;

  typedef enum logic [0:0] {
    CFG_IN_WIDTH  = 1'b0,
    CFG_OUT_WIDTH = 1'b1
  } cfg_reg_t;

  // Control fields of one accepted word.
  typedef struct packed {
    logic             flush;
    logic             ack_valid;
    logic [CNT_W-1:0] taken_count;
    logic             in_valid;
    logic [CNT_W-1:0] in_count;
    logic             out_stalled;
  } item_ctl_t;

  // Result control handed from the ring controller to the output stage.
  typedef struct packed {
    logic              replay_valid;
    logic [PC_W-1:0]   replay_pc;
    logic              pres_valid;
    logic [CNT_W-1:0]  pres_count;
    logic [LANE_W-1:0] head_bank;
  } pres_info_t;

  // Pointer plus offset, wrapped at the ring depth.
  function automatic logic [PTR_W-1:0] wrap_add(input logic [PTR_W-1:0] a,
                                                input logic [OCC_W-1:0] b);
    logic [SUM_W-1:0] sum;
    sum = SUM_W'(a) + SUM_W'(b);
    if (sum >= SUM_W'(BUFFER_DEPTH)) begin
      sum = sum - SUM_W'(BUFFER_DEPTH);
    end
    return PTR_W'(sum);
  endfunction

endpackage

// ----- src/fib_ram.sv -----
// Simple dual-port RAM bank with a registered, enabled read port.
module fib_ram #(
  parameter int DEPTH = 4,
  parameter int WIDTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- src/fib_ring_ctrl.sv -----
// Ring pointer state, pop/push/present arithmetic and bank addressing.
module fib_ring_ctrl (
  input  logic                                       clk,
  input  logic                                       rst_n,
  input  logic                                       move,
  input  fib_pkg::item_ctl_t                         item,
  input  fib_pkg::entry_t [fib_pkg::NUM_LANES-1:0]   entries,
  input  logic [fib_pkg::CFG_W-1:0]                  in_width,
  input  logic [fib_pkg::CFG_W-1:0]                  out_width,
  output logic [fib_pkg::NUM_LANES-1:0]              bank_we,
  output logic [fib_pkg::NUM_LANES-1:0][fib_pkg::ROW_W-1:0] bank_wrow,
  output fib_pkg::entry_t [fib_pkg::NUM_LANES-1:0]   bank_wdata,
  output logic [fib_pkg::NUM_LANES-1:0][fib_pkg::ROW_W-1:0] bank_rrow,
  output logic [fib_pkg::NUM_LANES-1:0]              bank_bypass,
  output fib_pkg::pres_info_t                        info
);

  logic [fib_pkg::PTR_W-1:0]  head_r, head_nxt;
  logic [fib_pkg::OCC_W-1:0]  occ_r, occ_nxt;

  logic [fib_pkg::OCC_W-1:0]  taken;
  logic [fib_pkg::OCC_W-1:0]  taken_req;
  logic [fib_pkg::PTR_W-1:0]  head_a;
  logic [fib_pkg::OCC_W-1:0]  occ_a;
  logic [fib_pkg::OCC_W-1:0]  room;
  logic                       fits;
  logic [fib_pkg::OCC_W-1:0]  lane_cnt;
  logic [fib_pkg::OCC_W-1:0]  push;
  logic [fib_pkg::OCC_W-1:0]  occ_b;
  logic [fib_pkg::PTR_W-1:0]  tail;
  logic [fib_pkg::OCC_W-1:0]  pres_lim;
  logic [fib_pkg::LANE_W-1:0] tail_bank;
  logic [fib_pkg::LANE_W-1:0] head_bank;

  always_comb begin
    // Acknowledge pops saturate at the current occupancy.
    taken_req = fib_pkg::OCC_W'(item.taken_count);
    if (!item.ack_valid) begin
      taken = '0;
    end else if (taken_req < occ_r) begin
      taken = taken_req;
    end else begin
      taken = occ_r;
    end
    head_a = fib_pkg::wrap_add(head_r, taken);
    occ_a  = occ_r - taken;

    room = fib_pkg::OCC_W'(fib_pkg::BUFFER_DEPTH) - occ_a;
    fits = (room >= fib_pkg::OCC_W'(in_width));

    if (fib_pkg::OCC_W'(item.in_count) < fib_pkg::OCC_W'(fib_pkg::NUM_LANES)) begin
      lane_cnt = fib_pkg::OCC_W'(item.in_count);
    end else begin
      lane_cnt = fib_pkg::OCC_W'(fib_pkg::NUM_LANES);
    end

    // A package that passes the room check but is bigger than the room left only pushes what fits.
    if (item.flush || !item.in_valid || !fits) begin
      push = '0;
    end else if (lane_cnt < room) begin
      push = lane_cnt;
    end else begin
      push = room;
    end

    occ_b     = occ_a + push;
    tail      = fib_pkg::wrap_add(head_a, occ_a);
    tail_bank = fib_pkg::LANE_W'(tail % fib_pkg::NUM_LANES);
    head_bank = fib_pkg::LANE_W'(head_a % fib_pkg::NUM_LANES);

    pres_lim = fib_pkg::OCC_W'(out_width);
    if (occ_b < pres_lim) begin
      pres_lim = occ_b;
    end
    if (fib_pkg::OCC_W'(fib_pkg::NUM_LANES) < pres_lim) begin
      pres_lim = fib_pkg::OCC_W'(fib_pkg::NUM_LANES);
    end

    info.replay_valid = !item.flush && item.in_valid && !fits;
    info.replay_pc    = info.replay_valid ? entries[0][fib_pkg::PC_W-1:0] : '0;
    info.pres_valid   = !item.flush && (occ_b != '0) && !item.out_stalled;
    info.pres_count   = info.pres_valid ? fib_pkg::CNT_W'(pres_lim) : '0;
    info.head_bank    = head_bank;

    if (item.flush) begin
      head_nxt = '0;
      occ_nxt  = '0;
    end else begin
      head_nxt = head_a;
      occ_nxt  = occ_b;
    end
  end

  // Consecutive ring slots fall in consecutive banks, so each bank sees at most
  // one write and one read per word.
  for (genvar b = 0; b < fib_pkg::NUM_LANES; b++) begin : g_bank
    logic [fib_pkg::LANE_W-1:0] wl;
    logic [fib_pkg::LANE_W-1:0] rl;
    logic [fib_pkg::PTR_W-1:0]  wslot;
    logic [fib_pkg::PTR_W-1:0]  rslot;

    assign wl    = fib_pkg::LANE_W'(b) - tail_bank;
    assign rl    = fib_pkg::LANE_W'(b) - head_bank;
    assign wslot = fib_pkg::wrap_add(tail, fib_pkg::OCC_W'(wl));
    assign rslot = fib_pkg::wrap_add(head_a, fib_pkg::OCC_W'(rl));

    assign bank_we[b]     = (fib_pkg::OCC_W'(wl) < push);
    assign bank_wrow[b]   = fib_pkg::ROW_W'(wslot / fib_pkg::NUM_LANES);
    assign bank_wdata[b]  = entries[wl];
    assign bank_rrow[b]   = fib_pkg::ROW_W'(rslot / fib_pkg::NUM_LANES);
    assign bank_bypass[b] = bank_we[b] && (bank_wrow[b] == bank_rrow[b]);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r <= '0;
      occ_r  <= '0;
    end else if (move) begin
      head_r <= head_nxt;
      occ_r  <= occ_nxt;
    end
  end

  a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
    occ_r <= fib_pkg::OCC_W'(fib_pkg::BUFFER_DEPTH))
    else $error("occupancy exceeds ring depth");

  a_flush_empties: assert property (@(posedge clk) disable iff (!rst_n)
    (move && item.flush) |=> (occ_r == '0 && head_r == '0))
    else $error("flush did not empty the ring");

  a_replay_no_push: assert property (@(posedge clk) disable iff (!rst_n)
    (move && info.replay_valid) |=> (occ_r <= $past(occ_r)))
    else $error("rejected package changed occupancy upward");

  a_present_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    (move && info.pres_valid) |=> (occ_r != '0))
    else $error("entries presented from an empty ring");

endmodule

// ----- src/fib_present.sv -----
// Output stage: result register, bank read-data steering and write bypass.
module fib_present (
  input  logic                                        clk,
  input  logic                                        rst_n,
  input  logic                                        move,
  input  logic                                        adv,
  input  fib_pkg::pres_info_t                         info,
  input  logic [fib_pkg::NUM_LANES-1:0]               bank_bypass,
  input  fib_pkg::entry_t [fib_pkg::NUM_LANES-1:0]    bank_wdata,
  input  fib_pkg::entry_t [fib_pkg::NUM_LANES-1:0]    bank_rdata,
  output logic                                        valid,
  output logic                                        replay_valid,
  output logic [fib_pkg::PC_W-1:0]                    replay_pc,
  output logic                                        pres_valid,
  output logic [fib_pkg::CNT_W-1:0]                   pres_count,
  output fib_pkg::entry_t [fib_pkg::LANE_FIELDS-1:0]  lanes
);

  logic                                     valid_r, valid_nxt;
  fib_pkg::pres_info_t                      info_r;
  logic [fib_pkg::NUM_LANES-1:0]            bypass_r;
  fib_pkg::entry_t [fib_pkg::NUM_LANES-1:0] wdata_r;

  assign valid_nxt = adv ? move : valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (move) begin
      info_r   <= info;
      bypass_r <= bank_bypass;
      wdata_r  <= bank_wdata;
    end
  end

  // An entry written in the same word as it is read comes from the write data.
  always_comb begin
    logic [fib_pkg::LANE_W-1:0] bank;
    lanes = '0;
    for (int j = 0; j < fib_pkg::NUM_LANES; j++) begin
      bank = fib_pkg::LANE_W'(info_r.head_bank + fib_pkg::LANE_W'(j));
      if (fib_pkg::CNT_W'(j) < info_r.pres_count) begin
        lanes[j] = bypass_r[bank] ? wdata_r[bank] : bank_rdata[bank];
      end
    end
  end

  assign valid        = valid_r;
  assign replay_valid = info_r.replay_valid;
  assign replay_pc    = info_r.replay_pc;
  assign pres_valid   = info_r.pres_valid;
  assign pres_count   = info_r.pres_count;

endmodule

// ----- src/fetch_instruction_buffer_unit.sv -----
// Fetch instruction buffer top level: input register, ring banks, output stage, config.
// A word moves from the input register to the output register (2 stages), one word per cycle
// unless stalled; the four RAM banks take at most one write and one read each per word.
// Stalls on the result side hold both stages and back-pressure the input through in_stall.
// Synchronous active-low reset empties the ring and sets both widths to 4; entries stay unset.
module fetch_instruction_buffer_unit (
  input  logic                              clk,
  input  logic                              rst_n,

  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic                              in_flush,
  input  logic                              in_ack_valid,
  input  logic [fib_pkg::CNT_W-1:0]         in_taken_count,
  input  logic                              in_in_valid,
  input  logic [fib_pkg::CNT_W-1:0]         in_in_count,
  input  logic [fib_pkg::ENTRY_W-1:0]       in_entry_zero,
  input  logic [fib_pkg::ENTRY_W-1:0]       in_entry_one,
  input  logic [fib_pkg::ENTRY_W-1:0]       in_entry_two,
  input  logic [fib_pkg::ENTRY_W-1:0]       in_entry_three,
  input  logic                              in_out_stalled,

  output logic                              out_valid,
  input  logic                              out_stall,
  output logic                              out_replay_valid,
  output logic [fib_pkg::PC_W-1:0]          out_replay_pc,
  output logic                              out_out_valid,
  output logic [fib_pkg::CNT_W-1:0]         out_out_count,
  output logic [fib_pkg::ENTRY_W-1:0]       out_out_zero,
  output logic [fib_pkg::ENTRY_W-1:0]       out_out_one,
  output logic [fib_pkg::ENTRY_W-1:0]       out_out_two,
  output logic [fib_pkg::ENTRY_W-1:0]       out_out_three,

  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [fib_pkg::APB_ADDR_W-1:0]    paddr,
  input  logic [fib_pkg::APB_DATA_W-1:0]    pwdata,
  output logic [fib_pkg::APB_DATA_W-1:0]    prdata,
  output logic                              pready
);

  logic [fib_pkg::CFG_W-1:0] in_width_r, in_width_nxt;
  logic [fib_pkg::CFG_W-1:0] out_width_r, out_width_nxt;
  fib_pkg::cfg_reg_t         cfg_sel;
  logic                      cfg_wr;

  logic                                        s1_valid_r, s1_valid_nxt;
  fib_pkg::item_ctl_t                          s1_item_r;
  fib_pkg::entry_t [fib_pkg::LANE_FIELDS-1:0]  s1_entries_r;
  fib_pkg::item_ctl_t                          in_item;
  fib_pkg::entry_t [fib_pkg::LANE_FIELDS-1:0]  in_entries;
  logic                                        in_take;
  logic                                        adv;
  logic                                        move;
  logic                                        s2_valid;

  logic [fib_pkg::NUM_LANES-1:0]                     bank_we;
  logic [fib_pkg::NUM_LANES-1:0][fib_pkg::ROW_W-1:0] bank_wrow;
  fib_pkg::entry_t [fib_pkg::NUM_LANES-1:0]          bank_wdata;
  logic [fib_pkg::NUM_LANES-1:0][fib_pkg::ROW_W-1:0] bank_rrow;
  logic [fib_pkg::NUM_LANES-1:0]                     bank_bypass;
  fib_pkg::entry_t [fib_pkg::NUM_LANES-1:0]          bank_rdata;
  fib_pkg::pres_info_t                               info;
  fib_pkg::entry_t [fib_pkg::LANE_FIELDS-1:0]        out_lanes;

  // Configuration registers.
  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign cfg_sel = fib_pkg::cfg_reg_t'(paddr[2]);

  always_comb begin
    in_width_nxt  = in_width_r;
    out_width_nxt = out_width_r;
    prdata        = '0;
    case (cfg_sel)
      fib_pkg::CFG_IN_WIDTH: begin
        prdata = fib_pkg::APB_DATA_W'(in_width_r);
        if (cfg_wr) begin
          in_width_nxt = pwdata[fib_pkg::CFG_W-1:0];
        end
      end
      fib_pkg::CFG_OUT_WIDTH: begin
        prdata = fib_pkg::APB_DATA_W'(out_width_r);
        if (cfg_wr) begin
          out_width_nxt = pwdata[fib_pkg::CFG_W-1:0];
        end
      end
      default: begin
        prdata = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_width_r  <= fib_pkg::CFG_W'(4);
      out_width_r <= fib_pkg::CFG_W'(4);
    end else begin
      in_width_r  <= in_width_nxt;
      out_width_r <= out_width_nxt;
    end
  end

  // Input register and pipeline advance.
  assign adv      = !s2_valid || !out_stall;
  assign move     = s1_valid_r && adv;
  assign in_stall = s1_valid_r && !adv;
  assign in_take  = in_valid && !in_stall;

  assign in_item.flush       = in_flush;
  assign in_item.ack_valid   = in_ack_valid;
  assign in_item.taken_count = in_taken_count;
  assign in_item.in_valid    = in_in_valid;
  assign in_item.in_count    = in_in_count;
  assign in_item.out_stalled = in_out_stalled;
  assign in_entries[0]       = in_entry_zero;
  assign in_entries[1]       = in_entry_one;
  assign in_entries[2]       = in_entry_two;
  assign in_entries[3]       = in_entry_three;

  assign s1_valid_nxt = in_take ? 1'b1 : (move ? 1'b0 : s1_valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_item_r    <= in_item;
      s1_entries_r <= in_entries;
    end
  end

  fib_ring_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .move        (move),
    .item        (s1_item_r),
    .entries     (s1_entries_r[fib_pkg::NUM_LANES-1:0]),
    .in_width    (in_width_r),
    .out_width   (out_width_r),
    .bank_we     (bank_we),
    .bank_wrow   (bank_wrow),
    .bank_wdata  (bank_wdata),
    .bank_rrow   (bank_rrow),
    .bank_bypass (bank_bypass),
    .info        (info)
  );

  for (genvar b = 0; b < fib_pkg::NUM_LANES; b++) begin : g_ram
    fib_ram #(
      .DEPTH (fib_pkg::ROW_DEPTH),
      .WIDTH (fib_pkg::ENTRY_W)
    ) u_ram (
      .clk   (clk),
      .we    (move && bank_we[b]),
      .waddr (bank_wrow[b]),
      .wdata (bank_wdata[b]),
      .re    (move),
      .raddr (bank_rrow[b]),
      .rdata (bank_rdata[b])
    );
  end

  fib_present u_present (
    .clk          (clk),
    .rst_n        (rst_n),
    .move         (move),
    .adv          (adv),
    .info         (info),
    .bank_bypass  (bank_bypass),
    .bank_wdata   (bank_wdata),
    .bank_rdata   (bank_rdata),
    .valid        (s2_valid),
    .replay_valid (out_replay_valid),
    .replay_pc    (out_replay_pc),
    .pres_valid   (out_out_valid),
    .pres_count   (out_out_count),
    .lanes        (out_lanes)
  );

  assign out_valid     = s2_valid;
  assign out_out_zero  = out_lanes[0];
  assign out_out_one   = out_lanes[1];
  assign out_out_two   = out_lanes[2];
  assign out_out_three = out_lanes[3];

endmodule

// ----- sim/tb_fetch_instruction_buffer_unit.sv -----
// Self-checking testbench for the fetch instruction buffer top level.
`timescale 1ns / 1ps

module tb_fetch_instruction_buffer_unit;

  typedef struct packed {
    logic                      flush;
    logic                      ack_valid;
    logic [fib_pkg::CNT_W-1:0] taken_count;
    logic                      pkg_valid;
    logic [fib_pkg::CNT_W-1:0] pkg_count;
    logic                      out_stalled;
    fib_pkg::entry_t [3:0]     lane;
  } fetch_word_t;

  typedef struct packed {
    logic                      replay_valid;
    logic [fib_pkg::PC_W-1:0]  replay_pc;
    logic                      pres_valid;
    logic [fib_pkg::CNT_W-1:0] pres_count;
    fib_pkg::entry_t [3:0]     pres;
  } fetch_result_t;

  logic                           clk = 1'b0;
  logic                           rst_n = 1'b0;
  logic                           in_valid = 1'b0;
  logic                           in_stall;
  logic                           in_flush = 1'b0;
  logic                           in_ack_valid = 1'b0;
  logic [fib_pkg::CNT_W-1:0]      in_taken_count = '0;
  logic                           in_in_valid = 1'b0;
  logic [fib_pkg::CNT_W-1:0]      in_in_count = '0;
  fib_pkg::entry_t                in_entry_zero = '0;
  fib_pkg::entry_t                in_entry_one = '0;
  fib_pkg::entry_t                in_entry_two = '0;
  fib_pkg::entry_t                in_entry_three = '0;
  logic                           in_out_stalled = 1'b0;
  logic                           out_valid;
  logic                           out_stall = 1'b0;
  logic                           out_replay_valid;
  logic [fib_pkg::PC_W-1:0]       out_replay_pc;
  logic                           out_out_valid;
  logic [fib_pkg::CNT_W-1:0]      out_out_count;
  fib_pkg::entry_t                out_out_zero;
  fib_pkg::entry_t                out_out_one;
  fib_pkg::entry_t                out_out_two;
  fib_pkg::entry_t                out_out_three;
  logic                           psel = 1'b0;
  logic                           penable = 1'b0;
  logic                           pwrite = 1'b0;
  logic [fib_pkg::APB_ADDR_W-1:0] paddr = '0;
  logic [fib_pkg::APB_DATA_W-1:0] pwdata = '0;
  logic [fib_pkg::APB_DATA_W-1:0] prdata;
  logic                           pready;

  fetch_instruction_buffer_unit dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_flush(in_flush),
    .in_ack_valid(in_ack_valid), .in_taken_count(in_taken_count),
    .in_in_valid(in_in_valid), .in_in_count(in_in_count),
    .in_entry_zero(in_entry_zero), .in_entry_one(in_entry_one),
    .in_entry_two(in_entry_two), .in_entry_three(in_entry_three),
    .in_out_stalled(in_out_stalled),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_replay_valid(out_replay_valid), .out_replay_pc(out_replay_pc),
    .out_out_valid(out_out_valid), .out_out_count(out_out_count),
    .out_out_zero(out_out_zero), .out_out_one(out_out_one),
    .out_out_two(out_out_two), .out_out_three(out_out_three),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  // Predicted buffer state and register copies.
  fib_pkg::entry_t ring_mem [fib_pkg::BUFFER_DEPTH];
  int     ring_head = 0;
  int     ring_fill = 0;
  int     need_room = 4;
  int     show_max = 4;

  fetch_result_t pending [$];
  fetch_result_t seen_expect;
  int fail_count = 0;
  int hold_left = 0;
  bit gaps_on = 1'b1;
  bit stalls_on = 1'b1;

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("tb: failure");
    $finish;
  end

  function automatic fetch_result_t buffer_step(fetch_word_t w);
    fetch_result_t r;
    int taken;
    int cnt;
    int i;
    r = '0;
    if (w.flush) begin
      ring_head = 0;
      ring_fill = 0;
      return r;
    end
    if (w.ack_valid) begin
      taken = (int'(w.taken_count) < ring_fill) ? int'(w.taken_count) : ring_fill;
      ring_head = (ring_head + taken) % fib_pkg::BUFFER_DEPTH;
      ring_fill -= taken;
    end
    if (w.pkg_valid) begin
      if (fib_pkg::BUFFER_DEPTH - ring_fill >= need_room) begin
        cnt = (int'(w.pkg_count) < fib_pkg::NUM_LANES) ? int'(w.pkg_count)
                                                       : fib_pkg::NUM_LANES;
        // Lanes beyond the free room are dropped when the room check is set loose.
        for (i = 0; i < cnt && ring_fill < fib_pkg::BUFFER_DEPTH; i++) begin
          ring_mem[(ring_head + ring_fill) % fib_pkg::BUFFER_DEPTH] = w.lane[i];
          ring_fill++;
        end
      end else begin
        r.replay_valid = 1'b1;
        r.replay_pc = w.lane[0][fib_pkg::PC_W-1:0];
      end
    end
    if (ring_fill != 0 && !w.out_stalled) begin
      cnt = (show_max < ring_fill) ? show_max : ring_fill;
      if (cnt > fib_pkg::NUM_LANES) cnt = fib_pkg::NUM_LANES;
      r.pres_valid = 1'b1;
      r.pres_count = fib_pkg::CNT_W'(cnt);
      for (i = 0; i < cnt; i++) begin
        r.pres[i] = ring_mem[(ring_head + i) % fib_pkg::BUFFER_DEPTH];
      end
    end
    return r;
  endfunction

  task automatic check_field(string name, logic [63:0] exp_val, logic [63:0] act_val);
    if (act_val !== exp_val) begin
      $error("%s: expected %h, got %h", name, exp_val, act_val);
      fail_count++;
    end
  endtask

  // A result word is taken at the coming edge when valid is high and stall low.
  always @(negedge clk) begin
    if (rst_n && out_valid === 1'b1 && out_stall === 1'b0) begin
      if (pending.size() == 0) begin
        $error("result word arrived with nothing expected");
        fail_count++;
      end else begin
        seen_expect = pending.pop_front();
        check_field("replay_valid", 64'(seen_expect.replay_valid), 64'(out_replay_valid));
        check_field("replay_pc", 64'(seen_expect.replay_pc), 64'(out_replay_pc));
        check_field("out_valid", 64'(seen_expect.pres_valid), 64'(out_out_valid));
        check_field("out_count", 64'(seen_expect.pres_count), 64'(out_out_count));
        check_field("out_zero", seen_expect.pres[0], out_out_zero);
        check_field("out_one", seen_expect.pres[1], out_out_one);
        check_field("out_two", seen_expect.pres[2], out_out_two);
        check_field("out_three", seen_expect.pres[3], out_out_three);
      end
    end
  end

  // Receiver: random stalls, plus a counted hold-off when a test asks for one.
  always @(posedge clk) begin
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left = hold_left - 1;
    end else begin
      out_stall <= stalls_on && ($urandom_range(0, 99) < 10);
    end
  end

  task automatic send_word(fetch_word_t w);
    bit took;
    if (gaps_on && $urandom_range(0, 99) < 10) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_flush       <= w.flush;
    in_ack_valid   <= w.ack_valid;
    in_taken_count <= w.taken_count;
    in_in_valid    <= w.pkg_valid;
    in_in_count    <= w.pkg_count;
    in_entry_zero  <= w.lane[0];
    in_entry_one   <= w.lane[1];
    in_entry_two   <= w.lane[2];
    in_entry_three <= w.lane[3];
    in_out_stalled <= w.out_stalled;
    do begin
      @(negedge clk);
      took = (in_stall === 1'b0);
      if (took) pending.push_back(buffer_step(w));
      @(posedge clk);
    end while (!took);
  endtask

  task automatic drain_words();
    in_valid <= 1'b0;
    while (pending.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic apb_write(fib_pkg::cfg_reg_t idx, int value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= fib_pkg::APB_DATA_W'(value);
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_widths(int in_w, int out_w);
    drain_words();
    apb_write(fib_pkg::CFG_IN_WIDTH, in_w);
    need_room = in_w & 7;
    apb_write(fib_pkg::CFG_OUT_WIDTH, out_w);
    show_max = out_w & 7;
  endtask

  function automatic fib_pkg::entry_t rand_entry();
    return {$urandom, $urandom};
  endfunction

  function automatic fetch_word_t pkg_word(int count, bit stalled);
    fetch_word_t w;
    int i;
    w = '0;
    w.pkg_valid = 1'b1;
    w.pkg_count = fib_pkg::CNT_W'(count);
    w.out_stalled = stalled;
    for (i = 0; i < 4; i++) w.lane[i] = rand_entry();
    return w;
  endfunction

  function automatic fetch_word_t ack_word(int taken);
    fetch_word_t w;
    w = '0;
    w.ack_valid = 1'b1;
    w.taken_count = fib_pkg::CNT_W'(taken);
    return w;
  endfunction

  function automatic fetch_word_t rand_word(int ack_pct);
    fetch_word_t w;
    w = pkg_word(0, $urandom_range(0, 99) < 15);
    w.pkg_valid = $urandom_range(0, 99) < 70;
    w.pkg_count = ($urandom_range(0, 99) < 85) ? fib_pkg::CNT_W'($urandom_range(1, 4))
                                               : fib_pkg::CNT_W'($urandom_range(0, 7));
    w.ack_valid = $urandom_range(0, 99) < ack_pct;
    w.taken_count = ($urandom_range(0, 99) < 85) ? fib_pkg::CNT_W'($urandom_range(0, 4))
                                                 : fib_pkg::CNT_W'($urandom_range(5, 7));
    w.flush = $urandom_range(0, 99) < 2;
    if ($urandom_range(0, 99) < 3) w.lane = '1;
    return w;
  endfunction

  task automatic test_directed();
    fetch_word_t w;
    w = pkg_word(4, 1'b0);
    w.lane = '1;
    send_word(w);
    w = pkg_word(4, 1'b0);
    w.lane = '0;
    send_word(w);
    send_word(pkg_word(0, 1'b0));       // empty package still passes the room check
    send_word(pkg_word(7, 1'b0));       // count above the lane limit
    send_word(pkg_word(4, 1'b1));       // buffer now full, next stage stalled
    send_word(pkg_word(4, 1'b0));       // no room: replay
    w = pkg_word(4, 1'b0);
    w.lane[0][fib_pkg::PC_W-1:0] = '1;
    send_word(w);
    w = pkg_word(4, 1'b0);
    w.lane[0][fib_pkg::PC_W-1:0] = '0;
    send_word(w);
    send_word(ack_word(7));
    w = pkg_word(3, 1'b0);
    w.ack_valid = 1'b1;
    w.taken_count = 3'd4;
    send_word(w);
    w = pkg_word(4, 1'b0);
    w.flush = 1'b1;
    w.ack_valid = 1'b1;
    w.taken_count = 3'd2;
    send_word(w);                       // flush ignores the rest of the word
    send_word(ack_word(4));             // acknowledge on an empty buffer
    send_word(pkg_word(2, 1'b0));
    send_word(ack_word(7));             // pop saturates at the fill level
    send_word('0);
    send_word(pkg_word(1, 1'b0));
    send_word(ack_word(0));
  endtask

  task automatic test_widths();
    int pairs [8][2] = '{'{0, 0}, '{7, 7}, '{1, 4}, '{4, 1},
                         '{2, 3}, '{3, 2}, '{0, 7}, '{7, 0}};
    int p;
    int k;
    for (p = 0; p < 8; p++) begin
      set_widths(pairs[p][0], pairs[p][1]);
      for (k = 0; k < 5; k++) send_word(pkg_word(4, 1'b0));
      send_word(ack_word(1));
      send_word(pkg_word(4, 1'b0));
      send_word(pkg_word(0, 1'b0));
      for (k = 0; k < 50; k++) send_word(rand_word((k < 25) ? 20 : 80));
    end
  endtask

  task automatic test_backpressure();
    int k;
    set_widths(4, 4);
    @(negedge clk);
    hold_left = 300;
    @(posedge clk);
    for (k = 0; k < 40; k++) send_word(rand_word(50));
  endtask

  task automatic test_random();
    int ph;
    int k;
    for (ph = 0; ph < 13; ph++) begin
      if ($urandom_range(0, 3) == 0)
        set_widths($urandom_range(0, 7), $urandom_range(0, 7));
      else
        set_widths($urandom_range(1, 4), $urandom_range(1, 4));
      // One long stretch runs with neither side idling.
      gaps_on = (ph != 5);
      stalls_on = (ph != 5);
      for (k = 0; k < 100; k++) send_word(rand_word((ph % 2 == 0) ? 25 : 75));
    end
    gaps_on = 1'b1;
    stalls_on = 1'b1;
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_widths();
    test_backpressure();
    test_random();
    drain_words();
    if (fail_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// ----- fetch_instruction_buffer_unit.f -----
src/fib_pkg.sv
src/fib_ram.sv
src/fib_ring_ctrl.sv
src/fib_present.sv
src/fetch_instruction_buffer_unit.sv
sim/tb_fetch_instruction_buffer_unit.sv
